>>> rtl/box_filter_mip_downsample_defines.svh
// ----------------------------------------------------------------------------
// box_filter_mip_downsample_defines.svh
// Assertion macros shared by the checker of the mip downsampler.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_MIP_DOWNSAMPLE_DEFINES_SVH
`define BOX_FILTER_MIP_DOWNSAMPLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFMD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFMD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/bfmd_pkg.sv
// ----------------------------------------------------------------------------
// bfmd_pkg
// Types and constants of the 2x2 box-filter mip downsampler.
// ----------------------------------------------------------------------------
package bfmd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int PIX_W      = 32;
    localparam int CH_N       = 4;
    localparam int CH_W       = 8;
    localparam int LANE_W     = 9;
    localparam int SUM_W      = CH_N * LANE_W;
    localparam int CFG_W      = 13;

    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W      = 12;
    localparam int OROW_W     = ROW_W - 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    // One finished pair sum on its way to the averaging stage.
    typedef struct packed {
        logic [SUM_W-1:0] pair;
        logic             last;
        logic             use_above;
    } stage_t;

endpackage

>>> rtl/bfmd_ram.sv
// ----------------------------------------------------------------------------
// bfmd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfmd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bfmd_regs.sv
// ----------------------------------------------------------------------------
// bfmd_regs
// APB register file: source width and height; any write restarts the image.
// ----------------------------------------------------------------------------
module bfmd_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bfmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bfmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [bfmd_pkg::CFG_W-1:0]      src_width,
    output logic [bfmd_pkg::CFG_W-1:0]      src_height,
    output logic                           restart
);
    import bfmd_pkg::*;

    logic [CFG_W-1:0]     src_width_reg;
    logic [CFG_W-1:0]     src_height_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign restart = wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= CFG_W'(1);
            src_height_reg <= CFG_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = APB_DATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = APB_DATA_W'(src_height_reg);
            default:        prdata = '0;
        endcase
    end

    assign src_width  = src_width_reg;
    assign src_height = src_height_reg;

endmodule

>>> rtl/bfmd_scan.sv
// ----------------------------------------------------------------------------
// bfmd_scan
// Raster position, horizontal pair sums and line-store access per pixel.
// ----------------------------------------------------------------------------
module bfmd_scan #(
    parameter int MAX_WIDTH = bfmd_pkg::MAX_WIDTH_DEF,
    localparam int DEPTH = (MAX_WIDTH + 1) / 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [bfmd_pkg::CFG_W-1:0]  src_width,
    input  logic [bfmd_pkg::CFG_W-1:0]  src_height,
    input  logic                       restart,
    input  logic                       accept,
    input  logic [bfmd_pkg::PIX_W-1:0]  pixel,
    output logic                       ram_we,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_addr,
    output logic [bfmd_pkg::SUM_W-1:0]  ram_wdata,
    output logic                       item_valid,
    output bfmd_pkg::stage_t           item
);
    import bfmd_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (EW > CFG_W) ? EW : CFG_W;

    function automatic logic [SUM_W-1:0] widen(input logic [PIX_W-1:0] p);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int c = 0; c < CH_N; c++) begin
            r[c*LANE_W +: LANE_W] = {1'b0, p[c*CH_W +: CH_W]};
        end
        return r;
    endfunction

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SUM_W-1:0] left_sum_reg, left_sum_next;

    logic [CMPW-1:0]  w_wide, w_clip;
    logic [EW-1:0]    w_eff;
    logic [CW-1:0]    w_m1;
    logic             w1;
    logic [AW-1:0]    ow_m1;
    logic [CFG_W-1:0] h_eff;
    logic [ROW_W-1:0] h_m1;
    logic             h1;
    logic [OROW_W-1:0] oh_m1;

    logic [AW-1:0]     x;
    logic [OROW_W-1:0] y;
    logic [SUM_W-1:0]  widened, pair;
    logic              have_pair;

    // Effective size: zero acts as one, oversize clips.
    always_comb begin
        w_wide = CMPW'(src_width);
        if (w_wide == '0) begin
            w_clip = CMPW'(1);
        end else if (w_wide > CMPW'(MAX_WIDTH)) begin
            w_clip = CMPW'(MAX_WIDTH);
        end else begin
            w_clip = w_wide;
        end
        if (src_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (src_height > CFG_W'(HEIGHT_LIMIT)) begin
            h_eff = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = src_height;
        end
    end

    assign w_eff = EW'(w_clip);
    assign w_m1  = CW'(w_eff - EW'(1));
    assign w1    = (w_eff == EW'(1));
    assign ow_m1 = w1 ? '0 : AW'((w_eff >> 1) - EW'(1));
    assign h_m1  = ROW_W'(h_eff - CFG_W'(1));
    assign h1    = (h_eff == CFG_W'(1));
    assign oh_m1 = h1 ? '0 : OROW_W'((h_eff >> 1) - CFG_W'(1));

    assign x = AW'(col_reg >> 1);
    assign y = row_reg[ROW_W-1:1];

    // Lanes never carry into each other: each 9-bit sum stays below 511.
    assign widened   = widen(pixel);
    assign pair      = w1 ? (widened + widened) : (left_sum_reg + widened);
    assign have_pair = w1 || col_reg[0];

    // Even rows park their pair sums; odd rows read them back.
    assign ram_we    = accept && have_pair && !h1 && !row_reg[0];
    assign ram_re    = accept && have_pair && !h1 && row_reg[0];
    assign ram_addr  = x;
    assign ram_wdata = pair;

    assign item_valid     = accept && have_pair && (h1 || row_reg[0]);
    assign item.pair      = pair;
    assign item.last      = (x == ow_m1) && (y == oh_m1);
    assign item.use_above = !h1;

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        left_sum_next = left_sum_reg;
        if (restart) begin
            col_next      = '0;
            row_next      = '0;
            left_sum_next = '0;
        end else if (accept) begin
            if (!have_pair) begin
                left_sum_next = widened;
            end
            if (col_reg == w_m1) begin
                col_next = '0;
                row_next = (row_reg == h_m1) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_sum_reg <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_sum_reg <= left_sum_next;
        end
    end

endmodule

>>> rtl/bfmd_avg.sv
// ----------------------------------------------------------------------------
// bfmd_avg
// Averaging stage and output register with valid/ready flow control.
// ----------------------------------------------------------------------------
module bfmd_avg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_valid,
    input  bfmd_pkg::stage_t           item,
    input  logic [bfmd_pkg::SUM_W-1:0]  above,
    output logic                       in_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bfmd_pkg::PIX_W-1:0]  m_avg_pixel,
    output logic                       m_last_of_image
);
    import bfmd_pkg::*;

    logic             s1_valid_reg;
    stage_t           s1_reg;
    logic             m_valid_reg;
    logic [PIX_W-1:0] avg_reg, avg_next;
    logic             last_reg;
    logic             out_free;

    logic [LANE_W:0]  lane_sum [CH_N];

    assign out_free = !m_valid_reg || m_ready;
    assign in_ready = !s1_valid_reg || out_free;

    // Full 2x2 sum drops two bits; a single-row pair drops one.
    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            lane_sum[c] = {1'b0, above[c*LANE_W +: LANE_W]}
                        + {1'b0, s1_reg.pair[c*LANE_W +: LANE_W]};
            if (s1_reg.use_above) begin
                avg_next[c*CH_W +: CH_W] = lane_sum[c][LANE_W:2];
            end else begin
                avg_next[c*CH_W +: CH_W] = s1_reg.pair[c*LANE_W+1 +: CH_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= item_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && item_valid) begin
            s1_reg <= item;
        end
        if (out_free && s1_valid_reg) begin
            avg_reg  <= avg_next;
            last_reg <= s1_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_avg_pixel     = avg_reg;
    assign m_last_of_image = last_reg;

endmodule

>>> rtl/box_filter_mip_downsample.sv
// ----------------------------------------------------------------------------
// box_filter_mip_downsample
// 2x2 box-filter mipmap downsampler: one source level in, next level out.
// ----------------------------------------------------------------------------
// Takes one 32-bit pixel per clock in raster order while the output is not
// stalled and emits one averaged pixel for every 2x2 source block through
// the stage register and the output register. Each pixel makes at most one
// access to the line store (a write on even rows, a read on odd rows).
// Writing src_width or src_height restarts the image; do it only while no
// item is in flight. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
module box_filter_mip_downsample #(
    parameter int MAX_WIDTH = bfmd_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bfmd_pkg::PIX_W-1:0]       s_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bfmd_pkg::PIX_W-1:0]       m_avg_pixel,
    output logic                            m_last_of_image,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfmd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bfmd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bfmd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bfmd_pkg::*;

    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic             restart;
    logic             accept;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_addr;
    logic [SUM_W-1:0] ram_wdata, ram_rdata;
    logic             item_valid;
    stage_t           item;

    assign accept = s_valid && s_ready;

    bfmd_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .src_width  (src_width),
        .src_height (src_height),
        .restart    (restart)
    );

    bfmd_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .src_width  (src_width),
        .src_height (src_height),
        .restart    (restart),
        .accept     (accept),
        .pixel      (s_pixel),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .item_valid (item_valid),
        .item       (item)
    );

    bfmd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    bfmd_avg u_avg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .above           (ram_rdata),
        .in_ready        (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_avg_pixel     (m_avg_pixel),
        .m_last_of_image (m_last_of_image)
    );

endmodule

>>> rtl/bfmd_checker.sv
// ----------------------------------------------------------------------------
// bfmd_checker
// Port-level checks of the mip downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_filter_mip_downsample_defines.svh"

module bfmd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [bfmd_pkg::PIX_W-1:0]      m_avg_pixel,
    input logic                           m_last_of_image
);

    // A stalled result holds its payload.
    `BFMD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_avg_pixel) && $stable(m_last_of_image))

    // With the output slot free, the input side never stalls.
    `BFMD_ASSERT_IMPLY(a_ready_when_free, aclk, aresetn, !m_valid || m_ready, s_ready)

    // A fresh result always traces back to an accepted item, passed on through the stage register.
    `BFMD_ASSERT_IMPLY(a_result_from_item, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind box_filter_mip_downsample bfmd_checker u_bfmd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_avg_pixel     (m_avg_pixel),
    .m_last_of_image (m_last_of_image)
);
